// File: hw/rtl/i2rn_pkg.sv
// shared types, constants and lookup tables for the integer to roman numeral unit
`timescale 1ns / 1ps
`default_nettype none
package i2rn_pkg;

  localparam int VALUE_W = 16;
  localparam int CHAR_W  = 8;
  localparam int REM_W   = 12;
  localparam int MULT_W  = 14;
  localparam int DIGIT_W = 4;
  localparam int DEC_W   = 2;
  localparam int POS_W   = 2;
  localparam int LEN_W   = 3;

  localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);
  localparam logic [CHAR_W-1:0]  ERR_CHAR  = '0;
  localparam logic [DEC_W-1:0]   DEC_ONES  = DEC_W'(3);

  // digit times decade weight, decades ordered thousands, hundreds, tens, ones
  localparam logic [MULT_W-1:0] DIGIT_MULT [4][10] = '{
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000,
      14'd8000, 14'd9000},
    '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700,
      14'd800, 14'd900},
    '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40, 14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
    '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ERR
  } state_t;

  // which letter of the decade a numeral position uses
  typedef enum logic [1:0] {
    K_UNIT,
    K_FIVE,
    K_TEN
  } kind_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic out_free;
    logic char_valid;
    logic final_char;
  } dp_sts_t;

  function automatic logic [LEN_W-1:0] pat_len(input logic [DIGIT_W-1:0] digit);
    logic [LEN_W-1:0] len;
    unique case (digit)
      4'd1, 4'd5:       len = LEN_W'(1);
      4'd2, 4'd4, 4'd6,
      4'd9:             len = LEN_W'(2);
      4'd3, 4'd7:       len = LEN_W'(3);
      4'd8:             len = LEN_W'(4);
      default:          len = '0;
    endcase
    return len;
  endfunction

  function automatic kind_t pat_kind(input logic [DIGIT_W-1:0] digit,
                                     input logic [POS_W-1:0]   pos);
    kind_t kind;
    unique case (digit)
      4'd4:             kind = (pos == '0) ? K_UNIT : K_FIVE;
      4'd5:             kind = K_FIVE;
      4'd6, 4'd7, 4'd8: kind = (pos == '0) ? K_FIVE : K_UNIT;
      4'd9:             kind = (pos == '0) ? K_UNIT : K_TEN;
      default:          kind = K_UNIT;
    endcase
    return kind;
  endfunction

  function automatic logic [CHAR_W-1:0] letter(input logic [DEC_W-1:0] dec,
                                               input kind_t            kind);
    logic [CHAR_W-1:0] code;
    code = ERR_CHAR;
    unique case (dec)
      2'd0: code = (kind == K_UNIT) ? "M" : ERR_CHAR;
      2'd1: code = (kind == K_UNIT) ? "C" : ((kind == K_FIVE) ? "D" : "M");
      2'd2: code = (kind == K_UNIT) ? "X" : ((kind == K_FIVE) ? "L" : "C");
      default: code = (kind == K_UNIT) ? "I" : ((kind == K_FIVE) ? "V" : "X");
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/i2rn_ctrl.sv
// controller state machine for the integer to roman numeral unit
`timescale 1ns / 1ps
`default_nettype none
module i2rn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire i2rn_pkg::dp_sts_t sts,
  output i2rn_pkg::dp_cmd_t      cmd
);

  i2rn_pkg::state_t state_r;
  i2rn_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2rn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      i2rn_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.range_ok ? i2rn_pkg::ST_RUN : i2rn_pkg::ST_ERR;
        end
      end
      i2rn_pkg::ST_RUN: begin
        if (sts.out_free) begin
          cmd.advance = 1'b1;
          if (sts.char_valid && sts.final_char) begin
            state_nxt = i2rn_pkg::ST_IDLE;
          end
        end
      end
      i2rn_pkg::ST_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = i2rn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2rn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/i2rn_dp.sv
// datapath: remainder, decade and letter position registers, letter lookup, output register
`timescale 1ns / 1ps
`default_nettype none
module i2rn_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [i2rn_pkg::VALUE_W-1:0]  in_tdata,
  input  wire i2rn_pkg::dp_cmd_t             cmd,
  output i2rn_pkg::dp_sts_t                  sts,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [i2rn_pkg::CHAR_W-1:0]        out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  logic [i2rn_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [i2rn_pkg::DEC_W-1:0]   dec_r, dec_nxt;
  logic [i2rn_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [i2rn_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_err_r, out_err_nxt;

  logic [i2rn_pkg::DIGIT_W-1:0] digit;
  logic [i2rn_pkg::LEN_W-1:0]   len;
  logic [i2rn_pkg::REM_W-1:0]   rem_after;
  logic [i2rn_pkg::CHAR_W-1:0]  char_code;
  logic                         digit_end;
  logic                         out_free;

  // digit of the current decade: largest multiple of the weight not above the remainder
  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if ({{(i2rn_pkg::MULT_W - i2rn_pkg::REM_W){1'b0}}, rem_r} >=
          i2rn_pkg::DIGIT_MULT[dec_r][k]) begin
        digit = i2rn_pkg::DIGIT_W'(k);
      end
    end
  end

  assign len       = i2rn_pkg::pat_len(digit);
  assign char_code = i2rn_pkg::letter(dec_r, i2rn_pkg::pat_kind(digit, pos_r));
  assign rem_after = rem_r - i2rn_pkg::DIGIT_MULT[dec_r][digit][i2rn_pkg::REM_W-1:0];
  assign digit_end = (len == '0) || ({1'b0, pos_r} == len - i2rn_pkg::LEN_W'(1));
  assign out_free  = !out_valid_r || out_tready;

  assign sts.range_ok   = (in_tdata != '0) && (in_tdata <= i2rn_pkg::MAX_VALUE);
  assign sts.out_free   = out_free;
  assign sts.char_valid = (len != '0);
  // last letter once the remaining lower decades are all zero
  assign sts.final_char = digit_end && (rem_after == '0);

  always_comb begin
    rem_nxt       = rem_r;
    dec_nxt       = dec_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    priority if (cmd.load) begin
      rem_nxt = in_tdata[i2rn_pkg::REM_W-1:0];
      dec_nxt = '0;
      pos_nxt = '0;
    end else if (cmd.emit_err) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = i2rn_pkg::ERR_CHAR;
      out_last_nxt  = 1'b1;
      out_err_nxt   = 1'b1;
    end else if (cmd.advance) begin
      if (sts.char_valid) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = char_code;
        out_last_nxt  = sts.final_char;
        out_err_nxt   = 1'b0;
      end
      if (digit_end) begin
        rem_nxt = rem_after;
        dec_nxt = (dec_r == i2rn_pkg::DEC_ONES) ? dec_r : dec_r + i2rn_pkg::DEC_W'(1);
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + i2rn_pkg::POS_W'(1);
      end
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dec_r      <= dec_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule
`default_nettype wire

// File: hw/rtl/integer_to_roman_numeral_unit.sv
// top level of the integer to roman numeral unit
// Converts one unsigned 16-bit value per input transfer into its subtractive
// roman numeral, sent as a run of ASCII letters, one letter per output transfer,
// most significant letter first, with out_tlast on the final letter.
// A value of 0 or above 3999 gives one output transfer with letter code 0,
// out_tlast high and out_tuser (range error) high.
// The value is loaded, then the walk sends one letter per cycle while the
// output register is free, and spends a step on each zero digit met before
// the last letter. The rate is set by the single letter lookup that walks
// decade by decade over the stored remainder.
// in_tready is high only while no value is in work; the next value is taken
// while the last letter may still wait in the output register.
// The output register holds its letter while out_tready is low and the
// walk pauses until it is taken.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_tvalid; any value in work is discarded.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_roman_numeral_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [i2rn_pkg::VALUE_W-1:0] in_tdata,   // [15:0] value
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [i2rn_pkg::CHAR_W-1:0]       out_tdata,  // [7:0] char_code
  output logic                              out_tlast,
  output logic                              out_tuser   // [0] out_of_range
);

  i2rn_pkg::dp_cmd_t cmd;
  i2rn_pkg::dp_sts_t sts;

  i2rn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2rn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// File: hw/rtl/i2rn_chk.sv
// port-level checker for the integer to roman numeral unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
module i2rn_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [i2rn_pkg::CHAR_W-1:0]  out_tdata,
  input wire logic                         out_tlast,
  input wire logic                         out_tuser
);

  // stalled output holds its letter
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // a range error is a single zero-coded transfer
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == i2rn_pkg::ERR_CHAR))
    else $error("malformed range error transfer");

  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata == "I") || (out_tdata == "V") || (out_tdata == "X") ||
      (out_tdata == "L") || (out_tdata == "C") || (out_tdata == "D") ||
      (out_tdata == "M"))
    else $error("output is not a numeral letter");

  // one value in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a value is in work");

endmodule

bind integer_to_roman_numeral_unit i2rn_chk u_i2rn_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// File: tb/tb_integer_to_roman_numeral_unit.sv
// self-checking testbench for the integer to roman numeral unit
`timescale 1ns / 1ps
module tb_integer_to_roman_numeral_unit;

  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 136;
  localparam int          DRAIN_LIMIT  = 5000;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_TEXT,
    ROW_ERR
  } row_kind_t;

  typedef struct {
    logic [i2rn_pkg::VALUE_W-1:0] value;
    row_kind_t                    kind;
    string                        text;
  } stim_row_t;

  typedef struct packed {
    logic [i2rn_pkg::CHAR_W-1:0] code;
    logic                        last;
    logic                        range_err;
  } letter_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [i2rn_pkg::VALUE_W-1:0] in_tdata   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [i2rn_pkg::CHAR_W-1:0]  out_tdata;
  logic                         out_tlast;
  logic                         out_tuser;

  letter_t   letter_q [$];
  stim_row_t stim_tab [$];

  int values_sent     = 0;
  int letters_checked = 0;
  int range_errs_seen = 0;
  int mismatch_count  = 0;
  bit hold_off_req    = 1'b0;
  bit steady_phase    = 1'b0;

  integer_to_roman_numeral_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic void flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", what);
    end
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic int heavy_digit();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? 3 : ((r == 1) ? 7 : 8);
  endfunction

  // expected letters of one value, queued in order
  function automatic void predict_numeral(input logic [i2rn_pkg::VALUE_W-1:0] v);
    logic [i2rn_pkg::CHAR_W-1:0] unit_l [4];
    logic [i2rn_pkg::CHAR_W-1:0] five_l [4];
    logic [i2rn_pkg::CHAR_W-1:0] ten_l  [4];
    logic [i2rn_pkg::CHAR_W-1:0] run    [$];
    int                          dig    [4];
    unit_l = '{"M", "C", "X", "I"};
    five_l = '{i2rn_pkg::ERR_CHAR, "D", "L", "V"};
    ten_l  = '{i2rn_pkg::ERR_CHAR, "M", "C", "X"};
    if (v == '0 || v > i2rn_pkg::MAX_VALUE) begin
      letter_q.push_back('{code: i2rn_pkg::ERR_CHAR, last: 1'b1, range_err: 1'b1});
      return;
    end
    dig[0] = v / 1000;
    dig[1] = (v / 100) % 10;
    dig[2] = (v / 10) % 10;
    dig[3] = v % 10;
    for (int dec = 0; dec < 4; dec++) begin
      case (dig[dec])
        1, 2, 3: begin
          repeat (dig[dec]) run.push_back(unit_l[dec]);
        end
        4: begin
          run.push_back(unit_l[dec]);
          run.push_back(five_l[dec]);
        end
        5, 6, 7, 8: begin
          run.push_back(five_l[dec]);
          repeat (dig[dec] - 5) run.push_back(unit_l[dec]);
        end
        9: begin
          run.push_back(unit_l[dec]);
          run.push_back(ten_l[dec]);
        end
        default: ;
      endcase
    end
    foreach (run[i]) begin
      letter_q.push_back('{code: run[i], last: (i == run.size() - 1), range_err: 1'b0});
    end
  endfunction

  // offer one value and queue its letters once the transfer happens
  task automatic send_value(input logic [i2rn_pkg::VALUE_W-1:0] v, input row_kind_t kind,
                            input string text);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    values_sent++;
    case (kind)
      ROW_ERR:  letter_q.push_back('{code: i2rn_pkg::ERR_CHAR, last: 1'b1, range_err: 1'b1});
      ROW_TEXT: begin
        for (int i = 0; i < text.len(); i++) begin
          letter_q.push_back('{code: text[i], last: (i == text.len() - 1),
                               range_err: 1'b0});
        end
      end
      default:  predict_numeral(v);
    endcase
    gap = steady_phase ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= i2rn_pkg::VALUE_W'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random stalls, one long hold-off on request, checks each transfer
  initial begin : letter_sink
    int      hold_left;
    int      stall_left;
    logic    ready_next;
    letter_t got;
    letter_t want;
    hold_left  = 0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!steady_phase && $urandom_range(0, 99) < 30) begin
        stall_left = idle_len();
        ready_next = (stall_left == 0);
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = '{code: out_tdata, last: out_tlast, range_err: out_tuser};
        letters_checked++;
        if (out_tuser) range_errs_seen++;
        if (letter_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected letter %02h last %b err %b",
                                  got.code, got.last, got.range_err));
        end else begin
          want = letter_q.pop_front();
          if (got !== want) begin
            flag_mismatch($sformatf({"expected %02h ('%c') last %b err %b, ",
                                     "got %02h ('%c') last %b err %b"},
                                    want.code, want.code, want.last, want.range_err,
                                    got.code, got.code, got.last, got.range_err));
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [i2rn_pkg::VALUE_W-1:0] v;
    int                           sel;
    int                           drain_cycles;

    // directed rows: typed-in text where it is plain, predictor elsewhere
    stim_tab.push_back('{16'd0,     ROW_ERR,  ""});
    stim_tab.push_back('{16'd4000,  ROW_ERR,  ""});
    stim_tab.push_back('{16'hffff,  ROW_ERR,  ""});
    stim_tab.push_back('{16'd1,     ROW_TEXT, "I"});
    stim_tab.push_back('{16'd3999,  ROW_TEXT, "MMMCMXCIX"});
    stim_tab.push_back('{16'd3888,  ROW_TEXT, "MMMDCCCLXXXVIII"});
    stim_tab.push_back('{16'd3000,  ROW_TEXT, "MMM"});
    stim_tab.push_back('{16'd4,     ROW_TEXT, "IV"});
    stim_tab.push_back('{16'd5,     ROW_TEXT, "V"});
    stim_tab.push_back('{16'd9,     ROW_TEXT, "IX"});
    stim_tab.push_back('{16'd40,    ROW_TEXT, "XL"});
    stim_tab.push_back('{16'd90,    ROW_TEXT, "XC"});
    stim_tab.push_back('{16'd400,   ROW_TEXT, "CD"});
    stim_tab.push_back('{16'd500,   ROW_TEXT, "D"});
    stim_tab.push_back('{16'd900,   ROW_TEXT, "CM"});
    stim_tab.push_back('{16'd1234,  ROW_PRED, ""});
    stim_tab.push_back('{16'd2567,  ROW_PRED, ""});
    stim_tab.push_back('{16'd789,   ROW_PRED, ""});
    stim_tab.push_back('{16'd3606,  ROW_PRED, ""});
    stim_tab.push_back('{16'd1010,  ROW_PRED, ""});
    stim_tab.push_back('{16'd1948,  ROW_PRED, ""});
    stim_tab.push_back('{16'd2001,  ROW_PRED, ""});
    stim_tab.push_back('{16'd4096,  ROW_PRED, ""});
    stim_tab.push_back('{16'd32768, ROW_PRED, ""});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_tab[i]) begin
      send_value(stim_tab[i].value, stim_tab[i].kind, stim_tab[i].text);
    end

    // sender stands back until the directed letters have all come out
    in_tvalid <= 1'b0;
    wait (letter_q.size() == 0);
    @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 40) hold_off_req = 1'b1;
      if (n == 80) begin
        in_tvalid <= 1'b0;
        wait (letter_q.size() == 0);
        @(posedge clk);
      end
      steady_phase = (n >= 100 && n < 130);
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        v = i2rn_pkg::VALUE_W'($urandom_range(1, 3999));
      end else if (sel < 80) begin
        // long numerals: lower three digits from the three-to-four letter patterns
        v = i2rn_pkg::VALUE_W'($urandom_range(1, 3) * 1000 + heavy_digit() * 100 +
                               heavy_digit() * 10 + heavy_digit());
      end else if (sel < 90) begin
        v = i2rn_pkg::VALUE_W'($urandom_range(4000, 65535));
      end else if (sel < 95) begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = i2rn_pkg::MAX_VALUE;
          2:       v = i2rn_pkg::MAX_VALUE + 1'b1;
          default: v = i2rn_pkg::VALUE_W'(1);
        endcase
      end else begin
        v = i2rn_pkg::VALUE_W'($urandom());
      end
      send_value(v, ROW_PRED, "");
    end
    steady_phase = 1'b0;
    in_tvalid <= 1'b0;

    drain_cycles = 0;
    while (letter_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (letter_q.size() != 0) begin
      flag_mismatch($sformatf("%0d letters never arrived", letter_q.size()));
    end
    repeat (40) @(posedge clk);

    $display("converted %0d values into %0d letters, %0d of them range errors",
             values_sent, letters_checked, range_errs_seen);
    $display("covered every digit pattern, both range limits and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: integer_to_roman_numeral_unit.f
hw/rtl/i2rn_pkg.sv
hw/rtl/i2rn_ctrl.sv
hw/rtl/i2rn_dp.sv
hw/rtl/integer_to_roman_numeral_unit.sv
hw/rtl/i2rn_chk.sv
tb/tb_integer_to_roman_numeral_unit.sv
